### hw/rtl/vector_polar_cartesian_unit_defines.svh
// assertion macros for the vector polar/cartesian unit
`ifndef VECTOR_POLAR_CARTESIAN_UNIT_DEFINES_SVH
`define VECTOR_POLAR_CARTESIAN_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define VPC_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication, sampled on clk, off during reset
`define VPC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define VPC_CHECK(label, ante, cons)
`define VPC_CHECK_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/vpc_pkg.sv
// shared types, constants and tables of the vector polar/cartesian unit
package vpc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 8;
  // cordic x/y datapath width with guard bits and gain growth
  localparam int XW = 42;
  localparam int MAX_ITER = 32;

  localparam logic [24:0] DEG360 = 25'(360 << FRAC_BITS);
  localparam logic [24:0] DEG180 = 25'(180 << FRAC_BITS);
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  // ceil(2^32/360) and ceil(2^32/45), exact for the operand ranges used
  localparam logic [23:0] RECIP360 = 24'd11930465;
  localparam logic [26:0] RECIP45  = 27'd95443718;
  // bias that makes any angle plus delta non-negative before the wrap
  localparam int WRAP_TURNS = 92;
  localparam logic [33:0] WRAP_BIAS = 34'(longint'(WRAP_TURNS) * longint'(DEG360));

  typedef enum logic [2:0] {
    REQ_TO_POLAR = 3'd0,
    REQ_TO_CART  = 3'd1,
    REQ_ROTATE   = 3'd2,
    REQ_SCALE    = 3'd3,
    REQ_STRETCH  = 3'd4
  } vpc_req_e;

  // atan(2^-i) in binary turns, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [MAX_ITER] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [2:0]              req;
    logic signed [31:0]      xi;
    logic signed [31:0]      yi;
    logic signed [31:0]      op;
    logic [31:0]             op_abs;
    logic [24:0]             ang;
    logic [31:0]             len;
    logic signed [33:0]      str_sum;
    logic [33:0]             wv;
    logic [7:0]              q;
    logic [63:0]             prod;
    logic [39:0]             x0;
    logic [18:0]             k;
    logic [5:0]              m;
    logic [12:0]             t2;
    logic [31:0]             turn;
    logic                    ov;
    logic                    zero;
    logic                    vect;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic [31:0]             z;
  } vpc_item_t;

  typedef struct packed {
    logic      valid;
    vpc_item_t item;
  } vpc_stage_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [24:0]        ang;
    logic [31:0]        len;
    logic               ov;
  } vpc_out_t;

  typedef struct packed {
    logic     valid;
    vpc_out_t data;
  } vpc_res_t;

endpackage

### hw/rtl/vpc_cordic_stage.sv
// one registered cordic micro-rotation, shared by vectoring and rotation mode
module vpc_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  vpc_pkg::vpc_stage_t in,
  output vpc_pkg::vpc_stage_t out
);
  import vpc_pkg::*;

  logic                 vld;
  vpc_item_t            item_q;
  vpc_item_t            item_next;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 cw;

  // vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    item_next = in.item;
    dx = in.item.y >>> IDX;
    dy = in.item.x >>> IDX;
    cw = in.item.vect ? (!in.item.y[XW-1] && (in.item.y != '0)) : in.item.z[31];
    if (cw) begin
      item_next.x = in.item.x + dx;
      item_next.y = in.item.y - dy;
      item_next.z = in.item.z + ATAN_TURNS[IDX];
    end else begin
      item_next.x = in.item.x - dx;
      item_next.y = in.item.y + dy;
      item_next.z = in.item.z - ATAN_TURNS[IDX];
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      item_q <= item_next;
    end
  end

  assign out = '{valid: vld, item: item_q};

endmodule

### hw/rtl/vpc_prep.sv
// front pipeline: operation math, degree wrap, degree to turn and cordic setup
module vpc_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                req_valid,
  input  logic [2:0]          req_type,
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  logic [24:0]         angle_in,
  input  logic [31:0]         length_in,
  input  logic signed [31:0]  operand,
  output vpc_pkg::vpc_stage_t out
);
  import vpc_pkg::*;

  localparam int STAGES = 9;

  vpc_item_t            pipe [STAGES];
  vpc_item_t            nx [STAGES];
  logic [STAGES-1:0]    vld;
  logic signed [33:0]   addend;
  logic [33:0]          sabs;
  logic                 neg180;
  logic [47:0]          scaled;
  logic [41:0]          qprod;
  logic [63:0]          gprod;
  logic [51:0]          kprod;
  logic [18:0]          mnum;
  logic [45:0]          tprod;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [31:0]   zt;

  always_comb begin
    for (int i = 1; i < STAGES; i++) begin
      nx[i] = pipe[i-1];
    end

    // capture request, reduce angle, stretch sum, |factor|
    nx[0]         = '0;
    nx[0].req     = req_type;
    nx[0].xi      = x_in;
    nx[0].yi      = y_in;
    nx[0].op      = operand;
    nx[0].op_abs  = operand[31] ? 32'(-operand) : 32'(operand);
    nx[0].ang     = (angle_in >= DEG360) ? angle_in - DEG360 : angle_in;
    nx[0].len     = length_in;
    nx[0].str_sum = $signed({2'b00, length_in}) + $signed({{2{operand[31]}}, operand});

    // angle sum with wrap bias, scale product, stretch magnitude
    neg180 = ((pipe[0].req == REQ_SCALE) && pipe[0].op[31]) ||
             ((pipe[0].req == REQ_STRETCH) && pipe[0].str_sum[33]);
    if (pipe[0].req == REQ_ROTATE) begin
      addend = $signed({{2{pipe[0].op[31]}}, pipe[0].op});
    end else if (neg180) begin
      addend = $signed(34'(DEG180));
    end else begin
      addend = '0;
    end
    nx[1].wv   = 34'(pipe[0].ang) + 34'(addend) + WRAP_BIAS;
    nx[1].prod = 64'(pipe[0].len) * 64'(pipe[0].op_abs);
    sabs = pipe[0].str_sum[33] ? 34'(-pipe[0].str_sum) : 34'(pipe[0].str_sum);
    if (pipe[0].req == REQ_STRETCH) begin
      if (sabs[33:32] != 2'b00) begin
        nx[1].len = 32'hFFFF_FFFF;
        nx[1].ov  = 1'b1;
      end else begin
        nx[1].len = sabs[31:0];
      end
    end

    // whole turns of 360 degrees, scale rounding and saturation
    qprod    = 42'(pipe[1].wv[33:16]) * 42'(RECIP360);
    nx[2].q  = qprod[39:32];
    scaled   = 48'((pipe[1].prod + 64'd32768) >> FRAC_BITS);
    if (pipe[1].req == REQ_SCALE) begin
      if (scaled[47:32] != '0) begin
        nx[2].len = 32'hFFFF_FFFF;
        nx[2].ov  = 1'b1;
      end else begin
        nx[2].len = scaled[31:0];
      end
    end

    // wrapped angle and gain-compensated start length
    nx[3].ang = 25'(pipe[2].wv - 34'(pipe[2].q) * 34'(DEG360));
    gprod     = 64'(pipe[2].len) * 64'(INV_GAIN) + 64'h0080_0000;
    nx[3].x0  = gprod[63:24];

    // degrees split as 45*k + m
    kprod    = 52'(pipe[3].ang) * 52'(RECIP45);
    nx[4].k  = kprod[50:32];

    nx[5].m  = 6'(pipe[4].ang - 25'(32'(pipe[4].k) * 32'd45));

    // fraction of the turn from the remainder
    mnum     = {pipe[5].m, 13'd0} + 19'd22;
    tprod    = 46'(mnum) * 46'(RECIP45);
    nx[6].t2 = tprod[44:32];

    nx[7].turn = {pipe[6].k, 13'd0} + 32'(pipe[6].t2);

    // cordic start vector for either mode
    nx[8].vect = (pipe[7].req == REQ_TO_POLAR);
    nx[8].zero = (pipe[7].xi == '0) && (pipe[7].yi == '0);
    xs = XW'(pipe[7].xi) <<< GUARD_BITS;
    ys = XW'(pipe[7].yi) <<< GUARD_BITS;
    zt = $signed(pipe[7].turn);
    if (pipe[7].req == REQ_TO_POLAR) begin
      if (pipe[7].xi[31]) begin
        nx[8].x = -xs;
        nx[8].y = -ys;
        nx[8].z = 32'h8000_0000;
      end else begin
        nx[8].x = xs;
        nx[8].y = ys;
        nx[8].z = '0;
      end
    end else begin
      nx[8].y = '0;
      if ((zt > 32'sh4000_0000) || (zt < -32'sh4000_0000)) begin
        nx[8].x = -$signed(XW'(pipe[7].x0));
        nx[8].z = {~pipe[7].turn[31], pipe[7].turn[30:0]};
      end else begin
        nx[8].x = $signed(XW'(pipe[7].x0));
        nx[8].z = pipe[7].turn;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], req_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STAGES; i++) begin
        pipe[i] <= nx[i];
      end
    end
  end

  assign out = '{valid: vld[STAGES-1], item: pipe[STAGES-1]};

endmodule

### hw/rtl/vpc_post.sv
// back pipeline: gain removal, turn to degree, rounding, saturation, result select
`include "vector_polar_cartesian_unit_defines.svh"
module vpc_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  vpc_pkg::vpc_stage_t in,
  output vpc_pkg::vpc_res_t   out
);
  import vpc_pkg::*;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } vpc_sat_t;

  function automatic vpc_sat_t sat32(input logic signed [XW-1:0] v);
    vpc_sat_t r;
    r.ov  = 1'b1;
    if (!v[XW-1] && (v[XW-2:31] != '0)) begin
      r.val = 32'h7FFF_FFFF;
    end else if (v[XW-1] && (v[XW-2:31] != '1)) begin
      r.val = 32'h8000_0000;
    end else begin
      r.val = v[31:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  logic                 q1_vld;
  vpc_item_t            q1;
  logic [40:0]          ph;
  logic [31:0]          plh;
  logic [40:0]          zm;
  logic [31:0]          xo;
  logic [31:0]          yo;
  logic                 ovxy;
  logic [40:0]          ux;
  logic [63:0]          pl_n;
  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] ry;
  vpc_sat_t             sx;
  vpc_sat_t             sy;
  logic                 q2_vld;
  vpc_out_t             q2;
  vpc_out_t             q2_next;
  logic [42:0]          t;
  logic [34:0]          tr;
  logic [25:0]          d;
  logic [31:0]          tlen;
  logic                 ovt;
  logic [24:0]          deg;

  // products for length and angle, rounding of x and y
  always_comb begin
    ux   = in.item.x[XW-1] ? '0 : 41'(in.item.x[XW-2:0]);
    pl_n = 64'(ux[31:0]) * 64'(INV_GAIN);
    rx   = (in.item.x + XW'(128)) >>> GUARD_BITS;
    ry   = (in.item.y + XW'(128)) >>> GUARD_BITS;
    sx   = sat32(rx);
    sy   = sat32(ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
    end else if (en) begin
      q1_vld <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1   <= in.item;
      ph   <= 41'(ux[40:32]) * 41'(INV_GAIN);
      plh  <= pl_n[63:32];
      zm   <= 41'(in.item.z) * 41'd360;
      xo   <= sx.val;
      yo   <= sy.val;
      ovxy <= sx.ov || sy.ov;
    end
  end

  // final length, degree and result select
  always_comb begin
    t    = 43'(ph) + 43'(plh);
    tr   = 35'((t + 43'd128) >> GUARD_BITS);
    ovt  = (tr[34:32] != '0);
    tlen = ovt ? 32'hFFFF_FFFF : tr[31:0];
    d    = 26'((zm + 41'h8000) >> FRAC_BITS);
    deg  = (d >= 26'(DEG360)) ? 25'(d - 26'(DEG360)) : d[24:0];
    q2_next = '0;
    case (q1.req) inside
      REQ_TO_POLAR: begin
        q2_next.x   = q1.xi;
        q2_next.y   = q1.yi;
        q2_next.ang = q1.zero ? '0 : deg;
        q2_next.len = q1.zero ? '0 : tlen;
        q2_next.ov  = !q1.zero && ovt;
      end
      REQ_TO_CART, REQ_ROTATE, REQ_SCALE, REQ_STRETCH: begin
        q2_next.x   = xo;
        q2_next.y   = yo;
        q2_next.ang = q1.ang;
        q2_next.len = q1.len;
        q2_next.ov  = q1.ov || ovxy;
      end
      default: q2_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_vld <= 1'b0;
    end else if (en) begin
      q2_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2 <= q2_next;
    end
  end

  assign out = '{valid: q2_vld, data: q2};

  `VPC_CHECK_NEXT(a_unknown_zero, en && q1_vld && (q1.req > 3'(REQ_STRETCH)), (q2.x == '0) && (q2.len == '0) && !q2.ov)
  `VPC_CHECK_NEXT(a_polar_flag_len, en && q1_vld && (q1.req == REQ_TO_POLAR), !q2.ov || (q2.len == '1))
  `VPC_CHECK(a_deg_range, q2_vld, q2.ang < DEG360)

endmodule

### hw/rtl/vector_polar_cartesian_unit.sv
// top level of the vector polar/cartesian unit
//
//   channel   signals                                             dir
//   request   req_valid, req_stall, req_type, x_in, y_in,         in
//             angle_in, length_in, operand
//   result    res_valid, res_stall, x_out, y_out, angle_out,      out
//             length_out, overflow
//
// one request per cycle while req_stall is low; the pipeline has 9 front stages,
// one stage per cordic iteration, 2 back stages and the output register
// reset clears only the valid bits of every stage and of the output register
// the pipeline freezes only while the output register is held and its last stage
// is full; bubbles keep moving, and req_stall is high exactly while frozen
`include "vector_polar_cartesian_unit_defines.svh"
module vector_polar_cartesian_unit #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic [24:0]        angle_in,
  input  logic [31:0]        length_in,
  input  logic signed [31:0] operand,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic [24:0]        angle_out,
  output logic [31:0]        length_out,
  output logic               overflow
);
  import vpc_pkg::*;

  logic       en;
  logic       load;
  vpc_stage_t chain [CORDIC_ITERATIONS+1];
  vpc_res_t   post_res;
  vpc_out_t   res_q;

  // pipeline advance and output register load
  assign en        = !(res_valid && res_stall && post_res.valid);
  assign req_stall = !en;
  assign load      = !res_valid || !res_stall;

  vpc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req_type  (req_type),
    .x_in      (x_in),
    .y_in      (y_in),
    .angle_in  (angle_in),
    .length_in (length_in),
    .operand   (operand),
    .out       (chain[0])
  );

  // cordic iterations, one register stage each
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_iter
    vpc_cordic_stage #(.IDX(g)) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (chain[g]),
      .out (chain[g+1])
    );
  end

  vpc_post u_post (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (chain[CORDIC_ITERATIONS]),
    .out (post_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= post_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= post_res.data;
    end
  end

  assign x_out      = res_q.x;
  assign y_out      = res_q.y;
  assign angle_out  = res_q.ang;
  assign length_out = res_q.len;
  assign overflow   = res_q.ov;

  `VPC_CHECK_NEXT(a_blocked_kept, res_valid && res_stall && post_res.valid, res_valid && post_res.valid)
  `VPC_CHECK_NEXT(a_load_shows, load && post_res.valid, res_valid)
  `VPC_CHECK(a_angle_range, res_valid, angle_out < DEG360)

endmodule
